// File: hdl/fmo_pkg.sv
// shared constants, types and sine table builder for the fm operator oscillator
package fmo_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_PHASE_INC = 2'd0;
  localparam logic [1:0] CFG_FREQ_MULT = 2'd1;
  localparam logic [1:0] CFG_DETUNE    = 2'd2;
  localparam logic [1:0] CFG_WAVEFORM  = 2'd3;

  // waveform codes
  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_HALF     = 3'd1;
  localparam logic [2:0] WAVE_RECT     = 3'd2;
  localparam logic [2:0] WAVE_DOUBLE   = 3'd3;
  localparam logic [2:0] WAVE_DBL_RECT = 3'd4;
  localparam logic [2:0] WAVE_RAMP     = 3'd5;
  localparam logic [2:0] WAVE_SQUARE   = 3'd6;

  // field widths
  localparam int PHASE_W  = 32;
  localparam int MULT_W   = 16;
  localparam int DETUNE_W = 5;
  localparam int WAVE_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // sine table geometry
  localparam int SINE_DEPTH   = 1024;
  localparam int SINE_AW      = $clog2(SINE_DEPTH);
  localparam int SINE_QUARTER = SINE_DEPTH / 4;
  localparam int QUAD_SH      = SINE_AW - 2;
  localparam int FRAC_W       = 15;
  localparam int AMP_MAX      = 32767;

  // angle between neighboring table entries
  localparam real SINE_STEP = 3.14159265358979323846 / real'(2 * SINE_QUARTER);

  typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_DEPTH];

  // round(32767 * sin(2*pi*k/depth)), built from one quarter by symmetry
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    int        quarter [SINE_QUARTER+1];
    real       x;
    int        v;
    int        qd;
    int        rm;
    for (int i = 0; i <= SINE_QUARTER; i++) begin
      x = real'(AMP_MAX) * $sin(SINE_STEP * real'(i));
      v = $rtoi(x + 0.5);
      if (v > AMP_MAX) v = AMP_MAX;
      quarter[i] = v;
    end
    for (int i = 0; i < SINE_DEPTH; i++) begin
      qd = i >> QUAD_SH;
      rm = i & (SINE_QUARTER - 1);
      v  = qd[0] ? quarter[SINE_QUARTER - rm] : quarter[rm];
      if (qd[1]) v = -v;
      rom[i] = SAMPLE_W'(v);
    end
    return rom;
  endfunction

endpackage

// File: hdl/fm_operator_oscillator_core.sv
// fm operator oscillator: phase accumulator memory, interpolated sine rom, waveform shaping
//
// usage:
//   configuration: cfg_we writes cfg_wdata into register cfg_idx (0 phase increment,
//   1 frequency multiplier, 2 detune, 3 waveform); write only while the block is idle.
//   input channel: in_valid/in_stall carry one beat with in_action and in_modulation.
//   action 0 advances the phase and yields one sample; action 1 clears the phase and
//   yields nothing.
//   output channel: out_valid/out_stall carry one beat with out_sample.
// timing:
//   a sample reaches the output through the pipeline stages and output register; one
//   beat is accepted every cycle while in_stall is low. the phase memory is read and
//   written back once per beat; forwarding lets back-to-back beats see the fresh phase.
// reset:
//   rst_n clears the phase to zero, the registers to their defaults (multiplier 1024)
//   and empties the pipeline.
// stall:
//   while out_stall holds a waiting sample, the pipeline keeps moving into empty
//   slots; once the last stage is also full, in_stall goes high until out_stall drops.
module fm_operator_oscillator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fmo_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [fmo_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic signed [fmo_pkg::PHASE_W-1:0]  in_modulation,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fmo_pkg::SAMPLE_W-1:0] out_sample
);
  import fmo_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // configuration registers
  logic [PHASE_W-1:0]         pinc_r;
  logic [MULT_W-1:0]          mult_r;
  logic signed [DETUNE_W-1:0] detune_r;
  logic [WAVE_W-1:0]          wave_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pinc_r   <= '0;
      mult_r   <= MULT_W'(1024);
      detune_r <= '0;
      wave_r   <= WAVE_SINE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PHASE_INC: pinc_r   <= cfg_wdata[PHASE_W-1:0];
        CFG_FREQ_MULT: mult_r   <= cfg_wdata[MULT_W-1:0];
        CFG_DETUNE:    detune_r <= cfg_wdata[DETUNE_W-1:0];
        CFG_WAVEFORM:  wave_r   <= cfg_wdata[WAVE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: hold only when the output waits and the last stage is full
  logic adv;
  logic s5_vld_r;
  logic out_vld_r;
  logic out_load;

  assign out_load = !out_vld_r || !out_stall;
  assign adv      = out_load || !s5_vld_r;
  assign in_stall = !adv;

  // stage 1 inputs: scaled increment and detune term
  logic [PHASE_W+MULT_W-1:0] prod;
  logic [DETUNE_W-1:0]       sh_full;
  logic [3:0]                sh_amt;

  assign prod = pinc_r * mult_r;

  always_comb begin
    if (detune_r > 0) sh_full = DETUNE_W'(16) - DETUNE_W'(detune_r);
    else              sh_full = DETUNE_W'(16) + DETUNE_W'(detune_r);
    sh_amt = sh_full[3:0];
  end

  logic               s1_vld_r;
  logic               s1_action_r;
  logic [PHASE_W-1:0] s1_modoff_r;
  logic [PHASE_W-1:0] s1_inc_r;
  logic [PHASE_W-1:0] s1_term_r;
  logic               s1_dpos_r;
  logic               s1_dneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_action_r <= in_action;
      // the quarter offset shifted left by 5 wraps to zero
      s1_modoff_r <= {in_modulation[PHASE_W-6:0], 5'b0};
      s1_inc_r    <= prod[PHASE_W+9:10];
      s1_term_r   <= pinc_r >> sh_amt;
      s1_dpos_r   <= (detune_r > 0);
      s1_dneg_r   <= (detune_r < 0);
    end
  end

  // stage 2 inputs: net phase step
  logic [PHASE_W-1:0] delta;
  logic [PHASE_W-1:0] sub_amt;

  always_comb begin
    sub_amt = (s1_inc_r < s1_term_r) ? s1_inc_r : s1_term_r;
    if (s1_dpos_r)      delta = s1_inc_r + s1_term_r;
    else if (s1_dneg_r) delta = s1_inc_r - sub_amt;
    else                delta = s1_inc_r;
  end

  logic               s2_vld_r;
  logic               s2_action_r;
  logic [PHASE_W-1:0] s2_modoff_r;
  logic [PHASE_W-1:0] s2_delta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_action_r <= s1_action_r;
      s2_modoff_r <= s1_modoff_r;
      s2_delta_r  <= delta;
    end
  end

  // phase memory: read every cycle, last write forwarded
  logic [PHASE_W-1:0] phase_mem [1];
  logic [PHASE_W-1:0] ph_rdq_r;
  logic [PHASE_W-1:0] ph_wdat_r;
  logic               ph_fwd_r;
  logic               ph_init_r;
  logic [PHASE_W-1:0] ph_cur;
  logic [PHASE_W-1:0] ph_new;
  logic               ph_we;

  assign ph_we = adv && s2_vld_r;

  always_comb begin
    if (ph_fwd_r)       ph_cur = ph_wdat_r;
    else if (ph_init_r) ph_cur = ph_rdq_r;
    else                ph_cur = '0;
    ph_new = s2_action_r ? '0 : ph_cur + s2_delta_r;
  end

  always_ff @(posedge clk) begin
    if (ph_we) phase_mem[0] <= ph_new;
    ph_rdq_r <= phase_mem[0];
    if (ph_we) ph_wdat_r <= ph_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_fwd_r  <= 1'b0;
      ph_init_r <= 1'b0;
    end else begin
      ph_fwd_r <= ph_we;
      if (ph_we) ph_init_r <= 1'b1;
    end
  end

  // stage 3: phase index, only sample beats continue
  logic               s3_vld_r;
  logic [PHASE_W-1:0] s3_phase_r;
  logic [PHASE_W-1:0] s3_modoff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r && !s2_action_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_phase_r  <= ph_new;
      s3_modoff_r <= s2_modoff_r;
    end
  end

  logic [PHASE_W-1:0] idx;
  logic [SINE_AW-1:0] tidx;
  logic [SINE_AW-1:0] addr0;
  logic [SINE_AW-1:0] addr1;
  logic               dbl;

  always_comb begin
    idx   = s3_phase_r + s3_modoff_r;
    tidx  = idx[PHASE_W-1 -: SINE_AW];
    dbl   = (wave_r == WAVE_DOUBLE) || (wave_r == WAVE_DBL_RECT);
    addr0 = dbl ? {tidx[SINE_AW-2:0], 1'b0} : tidx;
    addr1 = addr0 + SINE_AW'(1);
  end

  // stage 4: sine rom, two registered read ports
  logic                       s4_vld_r;
  logic signed [SAMPLE_W-1:0] rom0_r;
  logic signed [SAMPLE_W-1:0] rom1_r;
  logic [FRAC_W-1:0]          s4_frac_r;
  logic [SAMPLE_W-1:0]        s4_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rom0_r    <= SINE_ROM[addr0];
      rom1_r    <= SINE_ROM[addr1];
      s4_frac_r <= idx[PHASE_W-SINE_AW-1 -: FRAC_W];
      s4_hi_r   <= idx[PHASE_W-1 -: SAMPLE_W];
    end
  end

  // stage 5: interpolation products
  logic signed [FRAC_W+1:0]  wa;
  logic signed [FRAC_W+1:0]  wb;
  logic signed [FRAC_W+17:0] p0;
  logic signed [FRAC_W+17:0] p1;

  always_comb begin
    wa = (FRAC_W+2)'(1 << FRAC_W) - signed'({2'b00, s4_frac_r});
    wb = signed'({2'b00, s4_frac_r});
    p0 = rom0_r * wa;
    p1 = rom1_r * wb;
  end

  logic signed [FRAC_W+17:0] s5_p0_r;
  logic signed [FRAC_W+17:0] s5_p1_r;
  logic [SAMPLE_W-1:0]       s5_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_p0_r <= p0;
      s5_p1_r <= p1;
      s5_hi_r <= s4_hi_r;
    end
  end

  // divide each term by 0x8000 toward zero, then shape the waveform
  logic signed [FRAC_W+17:0]  p0_adj;
  logic signed [FRAC_W+17:0]  p1_adj;
  logic signed [17:0]         interp;
  logic signed [17:0]         interp_neg;
  logic signed [SAMPLE_W-1:0] iv;
  logic signed [SAMPLE_W-1:0] iv_abs;
  logic signed [SAMPLE_W-1:0] sample;

  always_comb begin
    p0_adj     = s5_p0_r + (s5_p0_r[FRAC_W+17] ? (FRAC_W+18)'(AMP_MAX) : '0);
    p1_adj     = s5_p1_r + (s5_p1_r[FRAC_W+17] ? (FRAC_W+18)'(AMP_MAX) : '0);
    interp     = p0_adj[FRAC_W+17:FRAC_W] + p1_adj[FRAC_W+17:FRAC_W];
    interp_neg = -interp;
    iv         = interp[SAMPLE_W-1:0];
    iv_abs     = interp[17] ? interp_neg[SAMPLE_W-1:0] : interp[SAMPLE_W-1:0];
    case (wave_r)
      WAVE_SINE:     sample = iv;
      WAVE_HALF:     sample = interp[17] ? '0 : iv;
      WAVE_RECT:     sample = iv_abs;
      WAVE_DOUBLE:   sample = s5_hi_r[SAMPLE_W-1] ? '0 : iv;
      WAVE_DBL_RECT: sample = s5_hi_r[SAMPLE_W-1] ? '0 : iv_abs;
      WAVE_RAMP:     sample = {~s5_hi_r[SAMPLE_W-1], s5_hi_r[SAMPLE_W-2:0]};
      WAVE_SQUARE:   sample = s5_hi_r[SAMPLE_W-1] ? 16'sh7fff : 16'sh8000;
      default:       sample = '0;
    endcase
  end

  // output register
  logic signed [SAMPLE_W-1:0] out_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_sample_r <= sample;
  end

  assign out_valid  = out_vld_r;
  assign out_sample = out_sample_r;

endmodule

// File: verif/fm_operator_oscillator_core_test.sv
// self-checking testbench for the fm operator oscillator core
module fm_operator_oscillator_core_test;
  import fmo_pkg::*;

  localparam logic       ACT_SAMPLE = 1'b0;
  localparam logic       ACT_CLEAR  = 1'b1;
  localparam logic [2:0] WAVE_NONE  = 3'd7;
  localparam int         PIPE_DEPTH = 5;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         RAND_PHASES = 13;
  localparam int         PHASE_BEATS = 35;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx = '0;
  logic [CFG_W-1:0]            cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_action = 1'b0;
  logic signed [PHASE_W-1:0]   in_modulation = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]  out_sample;

  fm_operator_oscillator_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_modulation (in_modulation),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's registers and phase
  logic [31:0] phase_acc = '0;
  logic [31:0] phase_inc = '0;
  logic [15:0] freq_mult = 16'd1024;
  int          detune_amt = 0;
  logic [2:0]  wave_sel = WAVE_SINE;
  int          sine_table [SINE_DEPTH];

  logic signed [15:0] pending_samples [$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  int  gap_odds = 0;

  // directed plan rows
  typedef struct {
    logic               is_cfg;
    logic [1:0]         idx;
    logic [31:0]        data;
    logic               action;
    logic [31:0]        mod;
    logic               known;
    logic signed [15:0] want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void cfg_row(input logic [1:0] idx, input logic [31:0] data);
    plan_row_t r;
    r = '{1'b1, idx, data, ACT_SAMPLE, 32'd0, 1'b0, 16'sd0};
    plan.push_back(r);
  endfunction

  function automatic void beat_row(input logic act, input logic [31:0] mod,
                                   input logic known, input logic signed [15:0] want);
    plan_row_t r;
    r = '{1'b0, 2'd0, 32'd0, act, mod, known, want};
    plan.push_back(r);
  endfunction

  // linear blend of two neighboring table entries, each term truncated toward zero
  function automatic int blend_sine(input logic [9:0] addr, input int frac);
    int w0;
    int w1;
    w0 = sine_table[addr];
    w1 = sine_table[10'(addr + 10'd1)];
    return (w0 * (32768 - frac)) / 32768 + (w1 * frac) / 32768;
  endfunction

  // advance the phase for one sample beat and shape the output
  function automatic logic signed [15:0] next_sample(input logic [31:0] mod);
    logic [63:0] prod;
    logic [31:0] step;
    logic [31:0] trim;
    logic [31:0] offs;
    logic [31:0] idx;
    logic [9:0]  tidx;
    int          frac;
    int          w;
    prod = {32'd0, phase_inc} * {48'd0, freq_mult};
    step = prod[41:10];
    phase_acc = phase_acc + step;
    if (detune_amt > 0) begin
      phase_acc = phase_acc + (phase_inc >> (16 - detune_amt));
    end else if (detune_amt < 0) begin
      trim = phase_inc >> (16 + detune_amt);
      if (step < trim) trim = step;
      phase_acc = phase_acc - trim;
    end
    offs = mod + 32'h4000_0000;
    offs = offs << 5;
    idx  = phase_acc + offs;
    tidx = idx[31:22];
    frac = int'(idx[21:7]);
    case (wave_sel)
      WAVE_SINE: w = blend_sine(tidx, frac);
      WAVE_HALF: begin
        w = blend_sine(tidx, frac);
        if (w < 0) w = 0;
      end
      WAVE_RECT: begin
        w = blend_sine(tidx, frac);
        if (w < 0) w = -w;
      end
      WAVE_DOUBLE: begin
        w = blend_sine({tidx[8:0], 1'b0}, frac);
        if (tidx[9]) w = 0;
      end
      WAVE_DBL_RECT: begin
        w = blend_sine({tidx[8:0], 1'b0}, frac);
        if (w < 0) w = -w;
        if (tidx[9]) w = 0;
      end
      WAVE_RAMP:   w = int'(idx[31:16]) - 32768;
      WAVE_SQUARE: w = tidx[9] ? 32767 : -32768;
      default:     w = 0;
    endcase
    return 16'(w);
  endfunction

  // one register write, mirrored into the shadow copy
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PHASE_INC: phase_inc = data;
      CFG_FREQ_MULT: freq_mult = data[15:0];
      CFG_DETUNE:    detune_amt = int'($signed(data[4:0]));
      CFG_WAVEFORM:  wave_sel = data[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // present one beat, hold it through stalls, then maybe go quiet for a burst
  task automatic send_beat(input logic act, input logic [31:0] mod,
                           input logic known, input logic signed [15:0] want);
    logic signed [15:0] s;
    in_valid      <= 1'b1;
    in_action     <= act;
    in_modulation <= mod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_SAMPLE) begin
      s = next_sample(mod);
      pending_samples.push_back(known ? want : s);
    end else begin
      phase_acc = '0;
    end
    if (!calm && gap_odds != 0 && $urandom_range(0, 9) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // wait for every sample in flight, then let clear beats drain from the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
  endtask

  // output side backpressure in bursts
  initial begin
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        if ($urandom_range(0, 2) != 0) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("sample: expected none, got %0d", out_sample);
        fail_count++;
      end else begin
        want = pending_samples.pop_front();
        if (out_sample !== want) begin
          $error("sample: expected %0d, got %0d", want, out_sample);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int          quarter [SINE_QUARTER+1];
    real         x;
    int          q;
    int          r;
    int          v;
    logic        prev_cfg;
    logic [31:0] junk;
    logic [31:0] mod;
    logic        act;

    // quarter wave, then mirrored into the full table
    for (int k = 0; k <= SINE_QUARTER; k++) begin
      x = 32767.0 * $sin(3.14159265358979323846 * real'(k) / 512.0);
      v = $rtoi(x + 0.5);
      if (v > 32767) v = 32767;
      quarter[k] = v;
    end
    for (int k = 0; k < SINE_DEPTH; k++) begin
      q = k / SINE_QUARTER;
      r = k % SINE_QUARTER;
      v = (q % 2 == 1) ? quarter[SINE_QUARTER - r] : quarter[r];
      sine_table[k] = (q >= 2) ? -v : v;
    end

    // directed plan: table peaks, every waveform, detune extremes, phase clear
    beat_row(ACT_SAMPLE, 32'h0000_0000, 1'b1, 16'sd0);
    beat_row(ACT_SAMPLE, 32'hC200_0000, 1'b1, 16'sd32767);
    beat_row(ACT_SAMPLE, 32'hC600_0000, 1'b1, -16'sd32767);
    beat_row(ACT_SAMPLE, 32'h7FFF_FFFF, 1'b0, 16'sd0);
    beat_row(ACT_SAMPLE, 32'h8000_0000, 1'b0, 16'sd0);
    beat_row(ACT_CLEAR,  32'hFFFF_FFFF, 1'b0, 16'sd0);
    cfg_row(CFG_WAVEFORM, {29'd0, WAVE_SQUARE});
    beat_row(ACT_SAMPLE, 32'h0000_0000, 1'b1, -16'sd32768);
    beat_row(ACT_SAMPLE, 32'hC400_0000, 1'b1, 16'sd32767);
    cfg_row(CFG_WAVEFORM, {29'd0, WAVE_RAMP});
    beat_row(ACT_SAMPLE, 32'h0000_0000, 1'b1, -16'sd32768);
    beat_row(ACT_SAMPLE, 32'hFFFF_FFFF, 1'b0, 16'sd0);
    cfg_row(CFG_WAVEFORM, {29'd0, WAVE_NONE});
    beat_row(ACT_SAMPLE, 32'h1234_5678, 1'b1, 16'sd0);
    cfg_row(CFG_WAVEFORM, {29'd0, WAVE_HALF});
    beat_row(ACT_SAMPLE, 32'hC600_0000, 1'b1, 16'sd0);
    cfg_row(CFG_WAVEFORM, {29'd0, WAVE_RECT});
    beat_row(ACT_SAMPLE, 32'hC600_0000, 1'b1, 16'sd32767);
    cfg_row(CFG_WAVEFORM, {29'd0, WAVE_DOUBLE});
    beat_row(ACT_SAMPLE, 32'hC100_0000, 1'b1, 16'sd32767);
    beat_row(ACT_SAMPLE, 32'hC400_0000, 1'b1, 16'sd0);
    cfg_row(CFG_WAVEFORM, {29'd0, WAVE_DBL_RECT});
    beat_row(ACT_SAMPLE, 32'hC300_0000, 1'b1, 16'sd32767);
    cfg_row(CFG_WAVEFORM, {29'd0, WAVE_SINE});
    cfg_row(CFG_PHASE_INC, 32'hFFFF_FFFF);
    cfg_row(CFG_FREQ_MULT, 32'h0000_FFFF);
    cfg_row(CFG_DETUNE, 32'h0000_0010);
    beat_row(ACT_SAMPLE, 32'h0000_0000, 1'b0, 16'sd0);
    beat_row(ACT_SAMPLE, 32'h0765_4321, 1'b0, 16'sd0);
    cfg_row(CFG_DETUNE, 32'h0000_000F);
    beat_row(ACT_SAMPLE, 32'h0000_0000, 1'b0, 16'sd0);
    beat_row(ACT_SAMPLE, 32'hF000_0001, 1'b0, 16'sd0);
    cfg_row(CFG_FREQ_MULT, 32'h0000_0000);
    cfg_row(CFG_DETUNE, 32'h0000_001F);
    beat_row(ACT_SAMPLE, 32'h0000_0000, 1'b0, 16'sd0);
    cfg_row(CFG_DETUNE, 32'h0000_0001);
    beat_row(ACT_SAMPLE, 32'h0000_0000, 1'b0, 16'sd0);
    beat_row(ACT_CLEAR,  32'h0000_0000, 1'b0, 16'sd0);
    beat_row(ACT_SAMPLE, 32'h0000_0000, 1'b0, 16'sd0);

    // reset
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk, registers only touched once the pipeline is empty
    gap_odds = 2;
    prev_cfg = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!prev_cfg) settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_beat(plan[i].action, plan[i].mod, plan[i].known, plan[i].want);
      end
      prev_cfg = plan[i].is_cfg;
    end

    // random phases, each with its own register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      calm = (p == RAND_PHASES - 1);
      gap_odds = $urandom_range(0, 4);
      junk = $urandom;
      if (p == 0) begin
        write_reg(CFG_PHASE_INC, 32'h0000_0000);
        write_reg(CFG_FREQ_MULT, 32'h0000_0000);
        write_reg(CFG_DETUNE, 32'h0000_0010);
        write_reg(CFG_WAVEFORM, {29'd0, WAVE_SINE});
      end else if (p == 1) begin
        write_reg(CFG_PHASE_INC, 32'hFFFF_FFFF);
        write_reg(CFG_FREQ_MULT, {junk[31:16], 16'hFFFF});
        write_reg(CFG_DETUNE, {junk[31:5], 5'd15});
        write_reg(CFG_WAVEFORM, {junk[31:3], WAVE_SQUARE});
      end else begin
        // mostly slow steps so interpolation is exercised, sometimes wild ones
        case ($urandom_range(0, 3))
          0:       write_reg(CFG_PHASE_INC, $urandom);
          1:       write_reg(CFG_PHASE_INC, 32'($urandom_range(0, 1 << 16)));
          default: write_reg(CFG_PHASE_INC, 32'($urandom_range(0, 1 << 26)));
        endcase
        case ($urandom_range(0, 2))
          0:       write_reg(CFG_FREQ_MULT, {junk[31:16], 16'd1024});
          1:       write_reg(CFG_FREQ_MULT, {junk[31:16], 16'($urandom)});
          default: write_reg(CFG_FREQ_MULT, {junk[31:16], 16'($urandom_range(0, 4096))});
        endcase
        write_reg(CFG_DETUNE, {junk[31:5], 5'($urandom_range(0, 31))});
        write_reg(CFG_WAVEFORM, {junk[31:3], 3'($urandom_range(0, 7))});
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        act = ($urandom_range(0, 11) == 0) ? ACT_CLEAR : ACT_SAMPLE;
        case ($urandom_range(0, 4))
          0:       mod = 32'($urandom_range(0, 2047)) - 32'd1024;
          1:       mod = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
          2:       mod = 32'h0000_0000;
          default: mod = $urandom;
        endcase
        send_beat(act, mod, 1'b0, 16'sd0);
      end
    end

    // wrap up
    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
